### rtl/core/esc_pkg.sv
// Package for the elevator sweep controller.
// Holds the shaft size constants, operation codes, beat structs and floor helpers.
// No dependencies; imported by the top level of the block.
package esc_pkg;

    localparam int FLOORS = 128;
    localparam int ADDR_W = $clog2(FLOORS);
    localparam int FLOOR_W = 7;
    localparam int MOVES_W = 17;
    localparam int CALLS_W = 16;
    localparam int HEIGHT_W = 7;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd99;
    localparam logic [CALLS_W-1:0] CALL_MAX = '1;
    localparam logic [MOVES_W-1:0] MOVE_MAX = '1;
    localparam logic [FLOOR_W-1:0] FLOOR_ONE = 7'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_TWO = 7'd2;
    localparam logic [FLOOR_W-1:0] CAR_TOP = FLOOR_W'((FLOORS - 1) < 127 ? (FLOORS - 1) : 127);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CALL = 2'd1,
        OP_READ = 2'd2
    } op_e_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [FLOOR_W-1:0] floor;
    } item_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic [MOVES_W-1:0] total_moves;
        logic [CALLS_W-1:0] floor_calls;
        logic               bad_call;
    } result_t;

    function automatic logic floor_on_shaft(input logic [FLOOR_W-1:0] f);
        return int'(f) < FLOORS;
    endfunction

    function automatic logic [ADDR_W-1:0] floor_addr(input logic [FLOOR_W-1:0] f);
        logic [ADDR_W+FLOOR_W-1:0] wide;
        wide = (ADDR_W + FLOOR_W)'(f);
        return wide[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/esc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-floor call counters; no package dependencies.
module esc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/elevator_sweep_controller.sv
// Top level of the elevator sweep controller.
// Depends on esc_pkg and on esc_ram for the per-floor call counters.
//
// The block takes one item per clock cycle while item_stall is low and returns
// exactly one result beat per item. An item is captured in an input stage at its
// accept edge, where the call counter RAM is read at the item's floor; when the
// input stage advances, the car state, the pending bitmap and the counter are
// updated and the result register is loaded. The input stage stalls only while it
// holds an item and the result register is full and stalled. Call counters sit in
// a 128 by 16 RAM whose entries read as zero until first written, tracked by one
// flag per floor, so no clearing pass follows reset. The height register is always
// ready; the user must write it only while the block is idle, which the block
// itself does not enforce.
module elevator_sweep_controller
    import esc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HEIGHT_W-1:0] cfg_data
);

    logic                height_we;
    logic [HEIGHT_W-1:0] height_reg;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    item_t               s1_item_reg;
    logic                seen_reg;
    logic                fwd_hit_reg;
    logic                fwd_hit_next;
    logic [CALLS_W-1:0]  fwd_val_reg;

    logic [FLOOR_W-1:0]  car_pos_reg;
    logic [FLOOR_W-1:0]  car_pos_next;
    logic                heading_up_reg;
    logic                heading_up_next;
    logic                heading_down_reg;
    logic                heading_down_next;
    logic [FLOORS-1:0]   pending_reg;
    logic [FLOORS-1:0]   pending_next;
    logic [MOVES_W-1:0]  move_tally_reg;
    logic [MOVES_W-1:0]  move_tally_next;
    logic [FLOORS-1:0]   seen_flags_reg;

    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             result_next;

    logic                accept;
    logic                s1_adv;
    logic                s1_call;
    logic                s1_write;
    logic                s1_on_shaft;
    logic [ADDR_W-1:0]   s1_addr;
    logic [ADDR_W-1:0]   in_addr;
    logic [CALLS_W-1:0]  ram_rd_data;
    logic [CALLS_W-1:0]  count_old;
    logic [CALLS_W-1:0]  count_new;
    logic [FLOORS-1:0]   above_bits;

    assign cfg_ready = 1'b1;
    assign height_we = cfg_valid && cfg_ready;

    assign s1_adv = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_adv;
    assign accept = item_valid && !item_stall;

    assign in_addr = floor_addr(item.floor);
    assign s1_addr = floor_addr(s1_item_reg.floor);
    assign s1_on_shaft = floor_on_shaft(s1_item_reg.floor);
    assign s1_call = (op_e_t'(s1_item_reg.op) == OP_CALL);
    assign s1_write = s1_call && s1_on_shaft && (s1_item_reg.floor >= FLOOR_TWO)
                      && (s1_item_reg.floor <= height_reg);

    assign count_old = fwd_hit_reg ? fwd_val_reg : (seen_reg ? ram_rd_data : '0);
    assign count_new = (count_old == CALL_MAX) ? count_old : count_old + 1'b1;

    assign fwd_hit_next = s1_adv && s1_write && (s1_addr == in_addr);
    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign result_valid_next = s1_adv ? 1'b1 : (result_valid_reg && result_stall);

    esc_ram #(
        .WIDTH(CALLS_W),
        .DEPTH(FLOORS)
    ) u_call_ram (
        .clk     (clk),
        .wr_en   (s1_adv && s1_write),
        .wr_addr (s1_addr),
        .wr_data (count_new),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        logic [FLOOR_W-1:0] pos;
        logic               up;
        logic               down;
        logic [FLOORS-1:0]  pend;
        logic [MOVES_W-1:0] moves;

        pos = car_pos_reg;
        up = heading_up_reg;
        down = heading_down_reg;
        pend = pending_reg;
        moves = move_tally_reg;

        unique case (op_e_t'(s1_item_reg.op))
            OP_TICK:
            begin
                if (floor_on_shaft(pos))
                begin
                    pend[floor_addr(pos)] = 1'b0;
                end
            end
            OP_CALL:
            begin
                if (s1_write)
                begin
                    pend[s1_addr] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < FLOORS; i++)
        begin
            above_bits[i] = pend[i] && (i > int'(pos));
        end

        if (op_e_t'(s1_item_reg.op) == OP_TICK)
        begin
            if (!down || pos == FLOOR_ONE)
            begin
                up = |above_bits;
                down = !(|above_bits);
            end
            if (up)
            begin
                if (pos < CAR_TOP)
                begin
                    pos = pos + 1'b1;
                    moves = (moves == MOVE_MAX) ? moves : moves + 1'b1;
                end
            end
            else if (down && pos > FLOOR_ONE)
            begin
                pos = pos - 1'b1;
                moves = (moves == MOVE_MAX) ? moves : moves + 1'b1;
            end
        end

        car_pos_next = s1_adv ? pos : car_pos_reg;
        heading_up_next = s1_adv ? up : heading_up_reg;
        heading_down_next = s1_adv ? down : heading_down_reg;
        pending_next = s1_adv ? pend : pending_reg;
        move_tally_next = s1_adv ? moves : move_tally_reg;

        result_next.car_floor = pos;
        result_next.total_moves = moves;
        result_next.floor_calls = !s1_on_shaft ? '0 : (s1_write ? count_new : count_old);
        result_next.bad_call = s1_call && !s1_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            car_pos_reg <= FLOOR_ONE;
            heading_up_reg <= 1'b1;
            heading_down_reg <= 1'b0;
            pending_reg <= '0;
            move_tally_reg <= '0;
            seen_flags_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (height_we)
            begin
                height_reg <= cfg_data;
            end
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
            car_pos_reg <= car_pos_next;
            heading_up_reg <= heading_up_next;
            heading_down_reg <= heading_down_next;
            pending_reg <= pending_next;
            move_tally_reg <= move_tally_next;
            if (s1_adv && s1_write)
            begin
                seen_flags_reg[s1_addr] <= 1'b1;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            seen_reg <= seen_flags_reg[in_addr];
        end
        if (s1_adv && s1_write)
        begin
            fwd_val_reg <= count_new;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(heading_up_reg && heading_down_reg))
        else $error("Car is heading both up and down.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.car_floor != '0)
        else $error("Result beat reports floor zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        move_tally_reg >= $past(move_tally_reg))
        else $error("Move tally decreased.");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && result_valid_reg)
        else $error("Input stalled with a free pipeline.");

endmodule
